### sv/lcps_pkg.sv
// Package for the LED cube layer PWM scanner: beat structs, FSM states,
// register indexes and fixed constants. No dependencies.
package lcps_pkg;

    localparam int WORD_W    = 48;   // width of the column shift word
    localparam int LAYER_W   = 3;    // width of a layer index
    localparam int COORD_W   = 3;    // width of one voxel coordinate
    localparam int DUTY_IN_W = 8;    // width of the duty field on the input beat
    localparam int DUTY_W    = 7;    // stored duty, 0..100
    localparam int TIME_W    = 32;
    localparam int RES_W     = 4;
    localparam int IVL_W     = 20;
    localparam int PHASE_W   = 8;
    localparam int SLOT_W    = 9;    // slot count up to 256
    localparam int ON_W      = 9;    // on-slot count up to 256

    localparam logic [DUTY_W-1:0] FULL_DUTY = 7'd100;
    localparam logic [RES_W-1:0]  RES_MAX   = 4'd8;

    // floor(v / 100) = (v * 5243) >> 19 for every v up to 100 * 256
    localparam int DIV100_MUL_W = 13;
    localparam logic [DIV100_MUL_W-1:0] DIV100_MUL = 13'd5243;
    localparam int DIV100_SHIFT = 19;

    localparam logic [RES_W-1:0] RES_RESET = 4'd4;
    localparam logic [IVL_W-1:0] IVL_RESET = 20'd2778;

    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_PWM_RES   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_LAYER_IVL = 1'b1;

    localparam logic FUNC_WRITE   = 1'b0;
    localparam logic FUNC_REFRESH = 1'b1;

    typedef struct packed {
        logic                 func;
        logic [COORD_W-1:0]   voxel_x;
        logic [COORD_W-1:0]   voxel_y;
        logic [COORD_W-1:0]   voxel_z;
        logic [DUTY_IN_W-1:0] duty_percent;
        logic [TIME_W-1:0]    now_us;
    } in_beat_t;

    typedef struct packed {
        logic [WORD_W-1:0]  column_bits;
        logic [LAYER_W-1:0] layer_select;
    } out_beat_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN
    } scan_state_t;

endpackage

### sv/led_cube_layer_pwm_scanner_core.sv
// Top level of the LED cube layer PWM scanner.
// Depends on lcps_pkg and lcps_ram.
//
// s_* (valid/ready) carries lcps_pkg::in_beat_t. A beat with func clear writes
// one voxel duty (saturated at 100, dropped outside the cube) and gives no
// result; a beat with func set refreshes the active layer and gives exactly
// one m_* beat: the 48-bit column word (bit y*CUBE_EDGE+x) and its layer.
// cfg_* writes pwm_resolution_bits (index 0) or layer_interval_us (index 1);
// it is always ready. Write it only while no refresh is in work.
// Timing: the store has one read port, so the scan reads one voxel per cycle;
// each voxel passes the RAM read register and the two compare stages into
// the column word. One item is in work at a time.
// Reset: aresetn (synchronous, active low) clears control state, then a
// clearing pass writes zero to every store entry while s_ready stays low.
// Stall: the result sits in an output register and further beats are
// accepted while it waits. A refresh that finishes while the register is
// still full holds in its last state until m_ready frees it.
module led_cube_layer_pwm_scanner_core #(
    parameter int CUBE_EDGE = 6
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    // input beats
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  lcps_pkg::in_beat_t                    s_payload,
    // result beats
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output lcps_pkg::out_beat_t                   m_payload,
    // configuration writes
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [lcps_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [lcps_pkg::IVL_W-1:0]            cfg_data
);

    localparam int LAYER_SIZE = CUBE_EDGE * CUBE_EDGE;
    localparam int DEPTH      = LAYER_SIZE * CUBE_EDGE;
    localparam int ADDR_W     = $clog2(DEPTH);
    localparam int CNT_W      = $clog2(LAYER_SIZE);

    localparam logic [ADDR_W-1:0]           LAST_ADDR  = ADDR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0]            LAST_VOXEL = CNT_W'(LAYER_SIZE - 1);
    localparam logic [lcps_pkg::LAYER_W-1:0] LAST_LAYER =
        lcps_pkg::LAYER_W'(CUBE_EDGE - 1);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [lcps_pkg::RES_W-1:0] pwm_res_reg;
    logic [lcps_pkg::IVL_W-1:0] layer_ivl_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pwm_res_reg   <= lcps_pkg::RES_RESET;
            layer_ivl_reg <= lcps_pkg::IVL_RESET;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                lcps_pkg::CFG_PWM_RES:   pwm_res_reg   <= cfg_data[lcps_pkg::RES_W-1:0];
                lcps_pkg::CFG_LAYER_IVL: layer_ivl_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Resolution above eight acts as eight.
    logic [lcps_pkg::RES_W-1:0]  res_eff;
    logic [lcps_pkg::SLOT_W-1:0] slot_count;
    logic [lcps_pkg::SLOT_W-1:0] slot_mask;

    assign res_eff    = (pwm_res_reg > lcps_pkg::RES_MAX) ? lcps_pkg::RES_MAX : pwm_res_reg;
    assign slot_count = lcps_pkg::SLOT_W'(1) << res_eff;
    assign slot_mask  = slot_count - lcps_pkg::SLOT_W'(1);

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    lcps_pkg::scan_state_t state_reg, state_next;

    logic [ADDR_W-1:0] clr_addr_reg;
    logic [ADDR_W-1:0] scan_addr_reg;
    logic [CNT_W-1:0]  scan_cnt_reg;
    logic              rd_pend_reg;   // RAM read data valid this cycle
    logic              on_vld_reg;    // on-count stage valid this cycle
    logic              m_valid_reg;
    lcps_pkg::out_beat_t m_payload_reg;

    logic s_fire;
    logic is_write;
    logic is_refresh;
    logic in_cube;
    logic ram_wr_en;
    logic [ADDR_W-1:0] ram_wr_addr;
    logic [lcps_pkg::DUTY_W-1:0] ram_wr_data;
    logic ram_rd_en;
    logic out_load;
    logic out_free;

    logic [lcps_pkg::DUTY_W-1:0] duty_sat;
    logic [ADDR_W-1:0]           write_addr;

    assign s_fire     = s_valid && s_ready;
    assign is_write   = s_payload.func == lcps_pkg::FUNC_WRITE;
    assign is_refresh = s_payload.func == lcps_pkg::FUNC_REFRESH;
    assign out_free   = !m_valid_reg || m_ready;

    assign in_cube = (32'(s_payload.voxel_x) < CUBE_EDGE)
                  && (32'(s_payload.voxel_y) < CUBE_EDGE)
                  && (32'(s_payload.voxel_z) < CUBE_EDGE);

    assign duty_sat = (s_payload.duty_percent > 8'(lcps_pkg::FULL_DUTY))
                    ? lcps_pkg::FULL_DUTY
                    : s_payload.duty_percent[lcps_pkg::DUTY_W-1:0];

    // Linear address: z * edge^2 + y * edge + x.
    assign write_addr = ADDR_W'(32'(s_payload.voxel_z) * LAYER_SIZE
                              + 32'(s_payload.voxel_y) * CUBE_EDGE
                              + 32'(s_payload.voxel_x));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= lcps_pkg::ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next  = state_reg;
        s_ready     = 1'b0;
        ram_wr_en   = 1'b0;
        ram_wr_addr = write_addr;
        ram_wr_data = duty_sat;
        ram_rd_en   = 1'b0;
        out_load    = 1'b0;
        unique case (state_reg)
            lcps_pkg::ST_CLEAR: begin
                // Zero the store one entry per cycle.
                ram_wr_en   = 1'b1;
                ram_wr_addr = clr_addr_reg;
                ram_wr_data = '0;
                if (clr_addr_reg == LAST_ADDR) begin
                    state_next = lcps_pkg::ST_IDLE;
                end
            end
            lcps_pkg::ST_IDLE: begin
                // Always ready here, so valid alone marks the accepting edge.
                s_ready = 1'b1;
                if (s_valid && is_write) begin
                    ram_wr_en = in_cube;
                end else if (s_valid && is_refresh) begin
                    state_next = lcps_pkg::ST_SCAN;
                end
            end
            lcps_pkg::ST_SCAN: begin
                // Issue one voxel read per cycle across the layer.
                ram_rd_en = 1'b1;
                if (scan_cnt_reg == LAST_VOXEL) begin
                    state_next = lcps_pkg::ST_DRAIN;
                end
            end
            lcps_pkg::ST_DRAIN: begin
                // Wait for the compare stages to empty and the output slot to free.
                if (!rd_pend_reg && !on_vld_reg && out_free) begin
                    out_load   = 1'b1;
                    state_next = lcps_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = lcps_pkg::ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Per-refresh state: layer, phase, switch time
    // ------------------------------------------------------------------
    logic [lcps_pkg::LAYER_W-1:0] active_layer_reg;
    logic [lcps_pkg::PHASE_W-1:0] pwm_phase_reg;
    logic [lcps_pkg::TIME_W-1:0]  last_switch_reg;
    logic [lcps_pkg::LAYER_W-1:0] scan_layer_reg;
    logic [lcps_pkg::PHASE_W-1:0] scan_phase_reg;

    logic [lcps_pkg::TIME_W-1:0]  elapsed;
    logic                         layer_due;
    logic [lcps_pkg::SLOT_W-1:0]  phase_inc;

    assign elapsed   = s_payload.now_us - last_switch_reg;
    assign layer_due = elapsed >= lcps_pkg::TIME_W'(layer_ivl_reg);
    assign phase_inc = lcps_pkg::SLOT_W'(pwm_phase_reg) + lcps_pkg::SLOT_W'(1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_layer_reg <= '0;
            pwm_phase_reg    <= '0;
            last_switch_reg  <= '0;
        end else if (s_fire && is_refresh) begin
            // Advance phase and, once the interval has run out, the layer.
            pwm_phase_reg <= (phase_inc >= slot_count)
                           ? '0 : phase_inc[lcps_pkg::PHASE_W-1:0];
            if (layer_due) begin
                active_layer_reg <= (active_layer_reg == LAST_LAYER)
                                  ? '0 : active_layer_reg + 1'b1;
                last_switch_reg  <= s_payload.now_us;
            end
        end
    end

    // Snapshot for the scan; the live registers have already moved on.
    always_ff @(posedge aclk) begin
        if (s_fire && is_refresh) begin
            scan_layer_reg <= active_layer_reg;
            scan_phase_reg <= pwm_phase_reg;
        end
    end

    // ------------------------------------------------------------------
    // Address counters
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_addr_reg  <= '0;
            scan_cnt_reg  <= '0;
            scan_addr_reg <= '0;
        end else begin
            if (state_reg == lcps_pkg::ST_CLEAR) begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
            end
            if (s_fire && is_refresh) begin
                scan_cnt_reg  <= '0;
                scan_addr_reg <= ADDR_W'(32'(active_layer_reg) * LAYER_SIZE);
            end else if (ram_rd_en) begin
                scan_cnt_reg  <= scan_cnt_reg + 1'b1;
                scan_addr_reg <= scan_addr_reg + 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Duty store
    // ------------------------------------------------------------------
    logic [lcps_pkg::DUTY_W-1:0] rd_duty;

    lcps_ram #(
        .DATA_W (lcps_pkg::DUTY_W),
        .DEPTH  (DEPTH)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (scan_addr_reg),
        .rd_data (rd_duty)
    );

    // ------------------------------------------------------------------
    // PWM compare pipeline
    // Stage 1: on = floor(duty * 2^res / 100) by reciprocal multiply.
    // Stage 2: lit = duty > 0 and (phase * on) mod 2^res < on.
    // ------------------------------------------------------------------
    localparam int SCALED_W = lcps_pkg::DUTY_W + 8;
    localparam int PROD_W   = SCALED_W + lcps_pkg::DIV100_MUL_W;
    localparam int PPROD_W  = lcps_pkg::PHASE_W + lcps_pkg::ON_W;

    logic [SCALED_W-1:0]        duty_scaled;
    logic [PROD_W-1:0]          div_prod;
    logic [lcps_pkg::ON_W-1:0]  on_reg;
    logic                       nz_reg;
    logic [PPROD_W-1:0]         phase_prod;
    logic [lcps_pkg::ON_W-1:0]  phase_slot;
    logic                       lit;
    logic [LAYER_SIZE-1:0]      word_reg;

    assign duty_scaled = SCALED_W'(rd_duty) << res_eff;
    assign div_prod    = PROD_W'(duty_scaled) * PROD_W'(lcps_pkg::DIV100_MUL);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_pend_reg <= 1'b0;
            on_vld_reg  <= 1'b0;
        end else begin
            rd_pend_reg <= ram_rd_en;
            on_vld_reg  <= rd_pend_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_pend_reg) begin
            on_reg <= div_prod[lcps_pkg::DIV100_SHIFT +: lcps_pkg::ON_W];
            nz_reg <= rd_duty != '0;
        end
    end

    assign phase_prod = PPROD_W'(scan_phase_reg) * PPROD_W'(on_reg);
    assign phase_slot = phase_prod[lcps_pkg::ON_W-1:0] & slot_mask;
    assign lit        = nz_reg && (phase_slot < on_reg);

    // Voxels arrive in bit order; shift in at the top so the first lands at bit 0.
    always_ff @(posedge aclk) begin
        if (on_vld_reg) begin
            word_reg <= {lit, word_reg[LAYER_SIZE-1:1]};
        end
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_payload_reg.column_bits  <= lcps_pkg::WORD_W'(word_reg);
            m_payload_reg.layer_select <= scan_layer_reg;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_store_port_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(ram_wr_en && ram_rd_en))
        else $error("duty store written during a scan read");

    a_out_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |-> (!m_valid_reg || m_ready))
        else $error("result register overwritten before it was taken");

    a_layer_range: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(active_layer_reg) < CUBE_EDGE)
        else $error("active layer outside the cube");

    a_word_top_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((m_payload.column_bits >> LAYER_SIZE) == '0))
        else $error("column word has bits above the layer");

    a_pipe_in_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        on_vld_reg |-> (state_reg == lcps_pkg::ST_SCAN || state_reg == lcps_pkg::ST_DRAIN))
        else $error("compare stage busy outside a refresh");

endmodule

### sv/lcps_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
module lcps_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 256,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### bench/led_cube_layer_pwm_scanner_core_tb.sv
// Self-checking bench for led_cube_layer_pwm_scanner_core: voxel writes and
// layer refreshes against a cycle-free scoreboard of the scan, under random idling.
// Depends on lcps_pkg and the scanner RTL only.
module led_cube_layer_pwm_scanner_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int EDGE        = 6;
    localparam int VOXELS      = EDGE * EDGE * EDGE;
    // Let a full refresh pass, with margin, before touching the registers so a
    // trailing write beat has surely landed.
    localparam int SETTLE      = 2 * (EDGE * EDGE + 4);
    // Slowest correct run: ~1430 beats, each a full refresh plus the longest
    // source gap and sink stall, plus drains and the clearing pass after reset;
    // the limit leaves a wide margin over that.
    localparam int CYCLE_LIMIT = 800000;
    localparam int PHASE_ITEMS = 100;
    localparam int JUNK_W      = lcps_pkg::IVL_W - lcps_pkg::RES_W;

    logic                           aclk = 1'b0;
    logic                           aresetn;
    logic                           s_valid;
    logic                           s_ready;
    lcps_pkg::in_beat_t             s_payload;
    logic                           m_valid;
    logic                           m_ready;
    lcps_pkg::out_beat_t            m_payload;
    logic                           cfg_valid;
    logic                           cfg_ready;
    logic [lcps_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [lcps_pkg::IVL_W-1:0]     cfg_data;

    // Scoreboard copy of the scanner state and its registers.
    logic [lcps_pkg::DUTY_W-1:0]    duty_mem [VOXELS];
    logic [lcps_pkg::PHASE_W-1:0]   scan_phase;
    logic [lcps_pkg::LAYER_W-1:0]   scan_layer;
    logic [lcps_pkg::TIME_W-1:0]    switch_stamp_us;
    logic [lcps_pkg::RES_W-1:0]     res_bits;
    logic [lcps_pkg::IVL_W-1:0]     interval_us;

    // Column words still owed by the block, oldest first.
    lcps_pkg::out_beat_t            frame_q [$];

    // Bench time base for well-formed refresh sequences.
    logic [lcps_pkg::TIME_W-1:0]    clock_us;

    bit                   src_burst;
    bit                   snk_burst;
    int                   err_cnt;
    int                   cycle_cnt;
    int                   n_writes;
    int                   n_ignored;
    int                   n_refresh;
    int                   n_checked;
    int                   n_advance;
    int                   n_regs;

    led_cube_layer_pwm_scanner_core #(
        .CUBE_EDGE (EDGE)
    ) u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Watchdog: end the run once the cycle count reaches CYCLE_LIMIT.
    always @(posedge aclk) begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles, %0d frames outstanding",
                     $time, cycle_cnt, frame_q.size());
            $display("Some tests failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Scoreboard
    // ------------------------------------------------------------------

    // Bring the scoreboard to the post-reset state.
    function automatic void clear_scan_state();
        for (int i = 0; i < VOXELS; i++)
            duty_mem[i] = '0;
        scan_phase      = '0;
        scan_layer      = '0;
        switch_stamp_us = '0;
        res_bits        = lcps_pkg::RES_RESET;
        interval_us     = lcps_pkg::IVL_RESET;
    endfunction

    // Store one duty, clipped at full brightness; drop writes outside the cube.
    function automatic void store_duty(input lcps_pkg::in_beat_t b);
        logic [lcps_pkg::DUTY_IN_W-1:0] d;
        if (b.voxel_x < EDGE && b.voxel_y < EDGE && b.voxel_z < EDGE) begin
            d = (b.duty_percent > lcps_pkg::FULL_DUTY)
              ? lcps_pkg::DUTY_IN_W'(lcps_pkg::FULL_DUTY) : b.duty_percent;
            duty_mem[int'(b.voxel_z) * EDGE * EDGE + int'(b.voxel_y) * EDGE
                     + int'(b.voxel_x)] = d[lcps_pkg::DUTY_W-1:0];
            n_writes++;
        end else begin
            n_ignored++;
        end
    endfunction

    // Build the column word of the active layer at the current phase, then
    // advance the phase and, once the interval has run out, the layer.
    function automatic lcps_pkg::out_beat_t scan_layer_word(
        input logic [lcps_pkg::TIME_W-1:0] now);
        lcps_pkg::out_beat_t         f;
        int unsigned                 slots;
        int unsigned                 on_slots;
        int unsigned                 duty;
        int unsigned                 nxt;
        logic [lcps_pkg::TIME_W-1:0] elapsed;
        slots = 1 << ((res_bits > lcps_pkg::RES_MAX) ? int'(lcps_pkg::RES_MAX)
                                                      : int'(res_bits));
        f.column_bits = '0;
        for (int y = 0; y < EDGE; y++) begin
            for (int x = 0; x < EDGE; x++) begin
                duty = 32'(duty_mem[int'(scan_layer) * EDGE * EDGE + y * EDGE + x]);
                on_slots = (duty * slots) / 100;
                // Interleave the on-slots across the period.
                if (duty != 0 && ((int'(scan_phase) * on_slots) % slots) < on_slots)
                    f.column_bits[y * EDGE + x] = 1'b1;
            end
        end
        f.layer_select = scan_layer;

        // A phase left beyond a shortened period is used once, then wraps.
        nxt = int'(scan_phase) + 1;
        if (nxt >= slots)
            nxt = 0;
        scan_phase = nxt[lcps_pkg::PHASE_W-1:0];

        elapsed = now - switch_stamp_us;
        if (elapsed >= lcps_pkg::TIME_W'(interval_us)) begin
            scan_layer      = (scan_layer == EDGE - 1) ? '0 : scan_layer + 1'b1;
            switch_stamp_us = now;
            n_advance++;
        end
        return f;
    endfunction

    function automatic void check_frame(input lcps_pkg::out_beat_t got);
        lcps_pkg::out_beat_t want;
        if (frame_q.size() == 0) begin
            $display("%0t: result beat with nothing expected: column_bits=%h layer=%0d",
                     $time, got.column_bits, got.layer_select);
            err_cnt++;
            return;
        end
        want = frame_q.pop_front();
        n_checked++;
        if (got.column_bits !== want.column_bits) begin
            $display("%0t: column_bits mismatch: expected %h, actual %h",
                     $time, want.column_bits, got.column_bits);
            err_cnt++;
        end
        if (got.layer_select !== want.layer_select) begin
            $display("%0t: layer_select mismatch: expected %0d, actual %0d",
                     $time, want.layer_select, got.layer_select);
            err_cnt++;
        end
    endfunction

    // ------------------------------------------------------------------
    // Result side: take each beat, check it, then stall a random while.
    // ------------------------------------------------------------------
    initial begin : result_sink
        int stall;
        stall = 0;
        m_ready <= 1'b0;
        do @(posedge aclk); while (!aresetn);
        m_ready <= 1'b1;
        forever begin
            @(posedge aclk);
            if (m_valid && m_ready) begin
                check_frame(m_payload);
                stall = snk_burst ? 0 : $urandom_range(0, 5);
                if (stall > 0)
                    m_ready <= 1'b0;
            end else if (!m_ready) begin
                if (stall > 0)
                    stall--;
                if (stall == 0)
                    m_ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------

    function automatic lcps_pkg::in_beat_t make_beat(input logic fn, input int unsigned x,
                                                     input int unsigned y,
                                                     input int unsigned z,
                                                     input int unsigned d,
                                                     input logic [lcps_pkg::TIME_W-1:0] now);
        lcps_pkg::in_beat_t b;
        b.func         = fn;
        b.voxel_x      = x[lcps_pkg::COORD_W-1:0];
        b.voxel_y      = y[lcps_pkg::COORD_W-1:0];
        b.voxel_z      = z[lcps_pkg::COORD_W-1:0];
        b.duty_percent = d[lcps_pkg::DUTY_IN_W-1:0];
        b.now_us       = now;
        return b;
    endfunction

    // Send one beat after a random gap; keep valid high across back-to-back
    // beats so it is never dropped and raised in the same step.
    task automatic send_beat(input lcps_pkg::in_beat_t b);
        int gap;
        gap = src_burst ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_payload <= b;
        do @(posedge aclk); while (!s_ready);
        if (b.func == lcps_pkg::FUNC_WRITE) begin
            store_duty(b);
        end else begin
            frame_q.push_back(scan_layer_word(b.now_us));
            n_refresh++;
        end
    endtask

    // Hold the source until every owed frame is back, then let the block settle.
    task automatic drain_results();
        s_valid <= 1'b0;
        while (frame_q.size() != 0)
            @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [lcps_pkg::CFG_IDX_W-1:0] idx,
                             input logic [lcps_pkg::IVL_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        if (idx == lcps_pkg::CFG_PWM_RES)
            res_bits = data[lcps_pkg::RES_W-1:0];
        else
            interval_us = data;
        n_regs++;
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // Load both registers; junk in the unused data bits of the resolution write.
    task automatic set_config(input logic [lcps_pkg::RES_W-1:0] res,
                              input logic [lcps_pkg::IVL_W-1:0] ivl);
        logic [JUNK_W-1:0] junk;
        junk = JUNK_W'($urandom);
        write_reg(lcps_pkg::CFG_PWM_RES, {junk, res});
        write_reg(lcps_pkg::CFG_LAYER_IVL, ivl);
        src_burst = ($urandom_range(0, 3) == 0);
        snk_burst = ($urandom_range(0, 3) == 0);
    endtask

    // Time step between refreshes, sized to the interval so layers advance
    // every few refreshes, with exact-boundary and wild jumps mixed in.
    function automatic logic [lcps_pkg::TIME_W-1:0] next_step();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return lcps_pkg::TIME_W'(interval_us);
            2:       return (interval_us == 0) ? '0
                          : lcps_pkg::TIME_W'(interval_us - 1'b1);
            3:       return $urandom;
            default: return $urandom_range(0, int'(interval_us) / 2 + 1);
        endcase
    endfunction

    function automatic int unsigned pick_duty();
        case ($urandom_range(0, 5))
            0:       return 0;
            1:       return 100;
            2:       return $urandom_range(101, 255);
            default: return $urandom_range(1, 99);
        endcase
    endfunction

    // Mostly paint voxels (biased toward the layer on display) and refresh on
    // an advancing clock; the rest is dropped writes and refreshes at random
    // times. Dropped writes do not count toward the item total.
    task automatic run_traffic(input int n_items);
        int          sent;
        int unsigned pick;
        int unsigned x;
        int unsigned y;
        int unsigned z;
        sent = 0;
        while (sent < n_items) begin
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
                clock_us = clock_us + next_step();
                send_beat(make_beat(lcps_pkg::FUNC_REFRESH, $urandom_range(0, 7),
                                    $urandom_range(0, 7), $urandom_range(0, 7),
                                    $urandom_range(0, 255), clock_us));
                sent++;
            end else if (pick < 85) begin
                z = ($urandom_range(0, 2) != 0) ? int'(scan_layer) : $urandom_range(0, EDGE - 1);
                send_beat(make_beat(lcps_pkg::FUNC_WRITE, $urandom_range(0, EDGE - 1),
                                    $urandom_range(0, EDGE - 1), z, pick_duty(), $urandom));
                sent++;
            end else if (pick < 92) begin
                // Push at least one coordinate off the cube.
                x = $urandom_range(0, 7);
                y = $urandom_range(0, 7);
                z = $urandom_range(0, 7);
                case ($urandom_range(0, 2))
                    0:       x = $urandom_range(EDGE, 7);
                    1:       y = $urandom_range(EDGE, 7);
                    default: z = $urandom_range(EDGE, 7);
                endcase
                send_beat(make_beat(lcps_pkg::FUNC_WRITE, x, y, z,
                                    $urandom_range(0, 255), $urandom));
            end else begin
                send_beat(make_beat(lcps_pkg::FUNC_REFRESH, $urandom_range(0, 7),
                                    $urandom_range(0, 7), $urandom_range(0, 7),
                                    $urandom_range(0, 255), $urandom));
                sent++;
            end
            if ($urandom_range(0, 79) == 0)
                drain_results();
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset registers: blank cube, saturation, dropped writes, the exact
    // interval boundary and a time that wraps past zero.
    task automatic test_directed();
        send_beat(make_beat(lcps_pkg::FUNC_REFRESH, 0, 0, 0, 0, 32'd0));
        send_beat(make_beat(lcps_pkg::FUNC_WRITE, 0, 0, 0, 255, 32'hFFFF_FFFF));
        send_beat(make_beat(lcps_pkg::FUNC_WRITE, 5, 5, 0, 1, 32'd0));
        send_beat(make_beat(lcps_pkg::FUNC_WRITE, 5, 0, 0, 100, $urandom));
        send_beat(make_beat(lcps_pkg::FUNC_WRITE, 0, 5, 0, 101, $urandom));
        send_beat(make_beat(lcps_pkg::FUNC_WRITE, 1, 0, 0, 50, $urandom));
        send_beat(make_beat(lcps_pkg::FUNC_WRITE, 2, 0, 0, 0, $urandom));
        // All but the z=6 write would alias onto real voxels if the range check were missing.
        send_beat(make_beat(lcps_pkg::FUNC_WRITE, 6, 0, 0, 77, $urandom));
        send_beat(make_beat(lcps_pkg::FUNC_WRITE, 0, 7, 0, 77, $urandom));
        send_beat(make_beat(lcps_pkg::FUNC_WRITE, 0, 0, 6, 77, $urandom));
        send_beat(make_beat(lcps_pkg::FUNC_WRITE, 7, 7, 7, 255, $urandom));
        send_beat(make_beat(lcps_pkg::FUNC_REFRESH, 7, 7, 7, 255, 32'd100));
        send_beat(make_beat(lcps_pkg::FUNC_REFRESH, 0, 0, 0, 0, 32'd2777));
        send_beat(make_beat(lcps_pkg::FUNC_REFRESH, 0, 0, 0, 0, 32'd2778));
        send_beat(make_beat(lcps_pkg::FUNC_WRITE, 3, 3, 1, 255, $urandom));
        send_beat(make_beat(lcps_pkg::FUNC_REFRESH, 0, 0, 0, 0, 32'hFFFF_FFFF));
        send_beat(make_beat(lcps_pkg::FUNC_WRITE, 4, 2, 2, 33, $urandom));
        send_beat(make_beat(lcps_pkg::FUNC_REFRESH, 0, 0, 0, 0, 32'd5));
        send_beat(make_beat(lcps_pkg::FUNC_REFRESH, 0, 0, 0, 0, 32'h8000_0000));
        drain_results();
    endtask

    // Sweep the PWM resolution, including zero, the top of the range and
    // values past eight; going from large to small leaves the phase beyond
    // the new period.
    task automatic test_resolution_sweep();
        logic [lcps_pkg::RES_W-1:0] res_list [6] = '{4'd8, 4'd1, 4'd0, 4'd15, 4'd2, 4'd11};
        foreach (res_list[i]) begin
            set_config(res_list[i], lcps_pkg::IVL_W'($urandom_range(0, 3000)));
            run_traffic(PHASE_ITEMS);
            drain_results();
        end
    endtask

    // Sweep the layer interval: every refresh, one microsecond, the longest
    // values, then back to the reset value.
    task automatic test_interval_sweep();
        logic [lcps_pkg::IVL_W-1:0] ivl_list [5] =
            '{20'd0, 20'd1, 20'd1000000, 20'hFFFFF, 20'd2778};
        foreach (ivl_list[i]) begin
            set_config(lcps_pkg::RES_W'($urandom_range(0, 15)), ivl_list[i]);
            run_traffic(PHASE_ITEMS);
            drain_results();
        end
    endtask

    task automatic test_random_mix();
        repeat (2) begin
            set_config(lcps_pkg::RES_W'($urandom_range(0, 15)),
                       lcps_pkg::IVL_W'($urandom_range(0, 20'hFFFFF)));
            run_traffic(PHASE_ITEMS);
            drain_results();
        end
    endtask

    initial begin
        aresetn   <= 1'b0;
        s_valid   <= 1'b0;
        s_payload <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= lcps_pkg::CFG_PWM_RES;
        cfg_data  <= '0;
        src_burst = 1'b0;
        snk_burst = 1'b0;
        clock_us  = '0;
        clear_scan_state();

        // Hold reset, then release it; the clearing pass afterwards shows up as
        // s_ready low, which send_beat simply waits out.
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        test_directed();
        test_resolution_sweep();
        test_interval_sweep();
        test_random_mix();
        drain_results();

        $display("Covered %0d voxel writes (%0d off the cube), %0d refreshes with %0d layer",
                 n_writes, n_ignored, n_refresh, n_advance);
        $display("advances, %0d frames checked, %0d register writes, %0d cycles",
                 n_checked, n_regs, cycle_cnt);
        if (err_cnt == 0 && frame_q.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("%0d mismatches, %0d frames never returned", err_cnt, frame_q.size());
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

### led_cube_layer_pwm_scanner_core.f
sv/lcps_pkg.sv
sv/lcps_ram.sv
sv/led_cube_layer_pwm_scanner_core.sv
bench/led_cube_layer_pwm_scanner_core_tb.sv
